@@ sv/assert_macros.svh @@
// Assertion macros for the score event note decoder.
// Included by the RTL modules that check their own pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define SENDEC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sendec assertion failed");
// next-cycle implication, disabled in reset
`define SENDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sendec assertion failed");
`else
`define SENDEC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SENDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/sendec_pkg.sv @@
// Package for the score event note decoder: widths, event codes,
// duration table, pipeline structs. No dependencies.
package sendec_pkg;

    localparam int CHANNELS       = 4;
    localparam int DURATION_CODES = 64;

    localparam int CH_W      = 2;
    localparam int ID_W      = 8;
    localparam int DATA_W    = 8;
    localparam int SEMI_W    = 4;
    localparam int SLOT_W    = 8;
    localparam int VOL_W     = 8;
    localparam int SEC_W     = 13;
    localparam int MICRO_W   = 20;
    localparam int TEMPO_W   = 14;
    localparam int ICOUNT_W  = 4;
    localparam int IMAP_W    = 24;
    localparam int INSTR_W   = 3;
    localparam int BASE_W    = 16;
    localparam int PROD_W    = BASE_W + TEMPO_W;
    localparam int DUR_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = IMAP_W;

    localparam logic [ID_W-1:0]  ID_REST   = 8'd128;
    localparam logic [ID_W-1:0]  ID_INSTR  = 8'd129;
    localparam logic [ID_W-1:0]  ID_VOLUME = 8'd132;
    localparam logic [6:0]       REST_NOTE = 7'd90;
    localparam logic [VOL_W-1:0] VOLUME_RESET = 8'd60;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 14'd1;

    // note / 12 as (note * 171) >> 11, exact for notes up to 127
    localparam logic [7:0] OCT_RECIP = 8'd171;
    localparam int         OCT_SHIFT = 11;

    // x / 1e6 as ((x >> 6) * 17179) >> 28, low by at most one
    localparam logic [DUR_W-1:0]   MICRO_PER_SEC = 32'd1000000;
    localparam logic [14:0]        SEC_RECIP     = 15'd17179;
    localparam int                 SEC_PRE_SHIFT = 6;
    localparam int                 SEC_SHIFT     = 28;
    localparam logic [SEC_W-1:0]   MAX_SECONDS   = 13'd4294;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMPO       = 2'd0,
        CFG_INSTR_COUNT = 2'd1,
        CFG_INSTR_MAP   = 2'd2
    } t_cfg_idx;

    localparam logic [BASE_W-1:0] BASE_DUR [DURATION_CODES] = '{
        16'd26880, 16'd13440, 16'd6720,  16'd3360,  16'd1680, 16'd840,  16'd420, 16'd210,
        16'd40320, 16'd20160, 16'd10080, 16'd5040,  16'd2520, 16'd1260, 16'd630, 16'd315,
        16'd17920, 16'd8960,  16'd4480,  16'd2240,  16'd1120, 16'd560,  16'd280, 16'd140,
        16'd26880, 16'd13440, 16'd6720,  16'd3360,  16'd1680, 16'd840,  16'd420, 16'd210,
        16'd21504, 16'd10752, 16'd5376,  16'd2688,  16'd1344, 16'd672,  16'd336, 16'd168,
        16'd32256, 16'd16128, 16'd8064,  16'd4032,  16'd2016, 16'd1008, 16'd504, 16'd252,
        16'd23040, 16'd11520, 16'd5760,  16'd2880,  16'd1440, 16'd720,  16'd360, 16'd180,
        16'd34560, 16'd17280, 16'd8640,  16'd4320,  16'd2160, 16'd1080, 16'd540, 16'd270
    };

    typedef struct packed {
        logic              advance;
        logic              valid;
    } t_pipe_ctl;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [SEMI_W-1:0] semitone;
        logic [SLOT_W-1:0] slot;
        logic [VOL_W-1:0]  volume;
        logic [DUR_W-1:0]  total;
        logic              last;
    } t_note_req;

    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [SEMI_W-1:0]  semitone;
        logic [SLOT_W-1:0]  slot;
        logic [VOL_W-1:0]   volume;
        logic [SEC_W-1:0]   seconds;
        logic [MICRO_W-1:0] micro;
        logic               last;
    } t_note_res;

endpackage

@@ sv/sendec_event_if.sv @@
// Request channel carrying one score event per transfer.
// Depends on sendec_pkg.
interface sendec_event_if;
    import sendec_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel;
    logic [ID_W-1:0]   event_id;
    logic [DATA_W-1:0] event_data;
    logic              last_in_track;

    modport source (output valid, channel, event_id, event_data, last_in_track,
                    input ready);
    modport sink   (input valid, channel, event_id, event_data, last_in_track,
                    output ready);
endinterface

@@ sv/sendec_note_if.sv @@
// Result channel carrying one decoded note per transfer.
// Depends on sendec_pkg.
interface sendec_note_if;
    import sendec_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    out_channel;
    logic [SEMI_W-1:0]  semitone;
    logic [SLOT_W-1:0]  sample_slot;
    logic [VOL_W-1:0]   note_volume;
    logic [SEC_W-1:0]   duration_seconds;
    logic [MICRO_W-1:0] duration_micro;
    logic               track_done;

    modport source (output valid, out_channel, semitone, sample_slot, note_volume,
                    duration_seconds, duration_micro, track_done,
                    input ready);
    modport sink   (input valid, out_channel, semitone, sample_slot, note_volume,
                    duration_seconds, duration_micro, track_done,
                    output ready);
endinterface

@@ sv/score_event_note_decoder_unit.sv @@
// Score event note decoder, top level: four-channel note/tie state and
// result pipeline. Depends on sendec_pkg, sendec_event_if, sendec_note_if,
// sendec_time_split and assert_macros.svh.
//
// Takes one score event per clock unless the pipeline holds, and returns one
// decoded note when a note or rest ends its tie chain; control events and open
// ties give no result. Stages: input register, duration multiply and note
// split, channel state update with saturating accumulate, then a three-step
// seconds split (reciprocal multiply, back multiply, correction). The whole
// pipeline holds while a result waits at the output; i_evt.ready is low
// exactly then. Configuration is written through i_cfg_we/i_cfg_idx/
// i_cfg_data while the block is idle; index 3 is ignored.
`include "assert_macros.svh"

module score_event_note_decoder_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sendec_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sendec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sendec_event_if.sink                     i_evt,
    sendec_note_if.source                    o_note
);
    import sendec_pkg::*;

    // configuration
    logic [TEMPO_W-1:0]  r_tempo;
    logic [ICOUNT_W-1:0] r_icount;
    logic [IMAP_W-1:0]   r_imap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo  <= TEMPO_RESET;
            r_icount <= '0;
            r_imap   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TEMPO:       r_tempo  <= i_cfg_data[TEMPO_W-1:0];
                CFG_INSTR_COUNT: r_icount <= i_cfg_data[ICOUNT_W-1:0];
                CFG_INSTR_MAP:   r_imap   <= i_cfg_data[IMAP_W-1:0];
                default: ;
            endcase
        end
    end

    logic      advance;
    logic      res_valid;
    t_note_res res;

    assign advance     = !res_valid || o_note.ready;
    assign i_evt.ready = advance;

    // stage 0: input register
    logic              r_s0_valid;
    logic [CH_W-1:0]   r_s0_ch;
    logic [ID_W-1:0]   r_s0_id;
    logic [DATA_W-1:0] r_s0_data;
    logic              r_s0_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (advance) begin
            r_s0_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s0_ch   <= i_evt.channel;
            r_s0_id   <= i_evt.event_id;
            r_s0_data <= i_evt.event_data;
            r_s0_last <= i_evt.last_in_track;
        end
    end

    // stage 0 logic: duration product, octave and semitone
    logic [PROD_W-1:0] s0_prod;
    logic [6:0]        s0_note;
    logic [14:0]       s0_oct_prod;
    logic [3:0]        s0_oct;
    logic [6:0]        s0_oct12;
    logic [6:0]        s0_semi_full;
    logic [SLOT_W-1:0] s0_slot_base;

    assign s0_prod      = PROD_W'(BASE_DUR[r_s0_data[5:0]]) * PROD_W'(r_tempo);
    assign s0_note      = (r_s0_id == ID_REST) ? REST_NOTE : r_s0_id[6:0];
    assign s0_oct_prod  = 15'(s0_note) * 15'(OCT_RECIP);
    assign s0_oct       = s0_oct_prod[OCT_SHIFT +: 4];
    assign s0_oct12     = 7'(s0_oct) * 7'd12;
    assign s0_semi_full = s0_note - s0_oct12;
    assign s0_slot_base = (8'd9 - 8'(s0_oct)) << 1;

    // stage 1: state update
    logic              r_s1_valid;
    logic [CH_W-1:0]   r_s1_ch;
    logic [ID_W-1:0]   r_s1_id;
    logic [DATA_W-1:0] r_s1_data;
    logic              r_s1_last;
    logic [PROD_W-1:0] r_s1_prod;
    logic [SEMI_W-1:0] r_s1_semi;
    logic [SLOT_W-1:0] r_s1_slot_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_ch        <= r_s0_ch;
            r_s1_id        <= r_s0_id;
            r_s1_data      <= r_s0_data;
            r_s1_last      <= r_s0_last;
            r_s1_prod      <= s0_prod;
            r_s1_semi      <= s0_semi_full[SEMI_W-1:0];
            r_s1_slot_base <= s0_slot_base;
        end
    end

    // per-channel state
    logic [INSTR_W-1:0] r_instr    [CHANNELS];
    logic [VOL_W-1:0]   r_vol      [CHANNELS];
    logic               r_tie      [CHANNELS];
    logic [DUR_W-1:0]   r_acc      [CHANNELS];
    logic [SEMI_W-1:0]  r_pend_semi[CHANNELS];
    logic [SLOT_W-1:0]  r_pend_slot[CHANNELS];
    logic [VOL_W-1:0]   r_pend_vol [CHANNELS];

    logic               ch_ok;
    logic               is_ctrl;
    logic               is_note;
    logic [DUR_W:0]     acc_sum;
    logic [INSTR_W-1:0] n_instr;
    logic [VOL_W-1:0]   n_vol;
    logic               n_tie;
    logic [DUR_W-1:0]   n_acc;
    logic [SEMI_W-1:0]  n_pend_semi;
    logic [SLOT_W-1:0]  n_pend_slot;
    logic [VOL_W-1:0]   n_pend_vol;
    logic               emit;
    t_note_req          req;

    assign ch_ok   = (int'(r_s1_ch) < CHANNELS);
    assign is_ctrl = (r_s1_id > ID_REST) || r_s1_data[7];
    assign is_note = !r_tie[r_s1_ch] && !is_ctrl;
    assign acc_sum = (DUR_W+1)'(r_acc[r_s1_ch]) + (DUR_W+1)'(r_s1_prod);

    always_comb begin
        n_instr     = r_instr[r_s1_ch];
        n_vol       = r_vol[r_s1_ch];
        n_tie       = r_tie[r_s1_ch];
        n_acc       = r_acc[r_s1_ch];
        n_pend_semi = r_pend_semi[r_s1_ch];
        n_pend_slot = r_pend_slot[r_s1_ch];
        n_pend_vol  = r_pend_vol[r_s1_ch];
        emit        = 1'b0;
        if (r_tie[r_s1_ch]) begin
            // tied follow-on: id not examined
            n_acc = acc_sum[DUR_W] ? '1 : acc_sum[DUR_W-1:0];
            emit  = !r_s1_data[6] || r_s1_last;
            n_tie = r_s1_data[6] && !r_s1_last;
        end else if (is_ctrl) begin
            if ((r_s1_id == ID_INSTR) && (r_s1_data < 8'(r_icount))
                    && (r_s1_data[7:3] == '0)) begin
                n_instr = r_imap[INSTR_W*r_s1_data[2:0] +: INSTR_W];
            end
            if (r_s1_id == ID_VOLUME) begin
                n_vol = r_s1_data;
            end
        end else begin
            n_pend_vol  = (r_s1_id == ID_REST) ? '0 : r_vol[r_s1_ch];
            n_pend_semi = r_s1_semi;
            n_pend_slot = r_s1_slot_base + {1'b0, r_instr[r_s1_ch], 4'b0000};
            n_acc       = DUR_W'(r_s1_prod);
            emit        = !r_s1_data[6] || r_s1_last;
            n_tie       = r_s1_data[6] && !r_s1_last;
        end
        req.ch       = r_s1_ch;
        req.semitone = n_pend_semi;
        req.slot     = n_pend_slot;
        req.volume   = n_pend_vol;
        req.total    = n_acc;
        req.last     = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_instr[i] <= '0;
                r_vol[i]   <= VOLUME_RESET;
                r_tie[i]   <= 1'b0;
                r_acc[i]   <= '0;
            end
        end else if (advance && r_s1_valid && ch_ok) begin
            r_instr[r_s1_ch] <= n_instr;
            r_vol[r_s1_ch]   <= n_vol;
            r_tie[r_s1_ch]   <= n_tie;
            r_acc[r_s1_ch]   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid && ch_ok && is_note) begin
            r_pend_semi[r_s1_ch] <= n_pend_semi;
            r_pend_slot[r_s1_ch] <= n_pend_slot;
            r_pend_vol[r_s1_ch]  <= n_pend_vol;
        end
    end

    t_pipe_ctl split_ctl;

    assign split_ctl.advance = advance;
    assign split_ctl.valid   = r_s1_valid && ch_ok && emit;

    sendec_time_split u_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (split_ctl),
        .i_req       (req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_note.valid            = res_valid;
    assign o_note.out_channel      = res.ch;
    assign o_note.semitone         = res.semitone;
    assign o_note.sample_slot      = res.slot;
    assign o_note.note_volume      = res.volume;
    assign o_note.duration_seconds = res.seconds;
    assign o_note.duration_micro   = res.micro;
    assign o_note.track_done       = res.last;

    `SENDEC_ASSERT_IMPL(a_micro_range, i_clk, i_rst_n, o_note.valid, o_note.duration_micro <= MICRO_PER_SEC[MICRO_W-1:0])
    `SENDEC_ASSERT_IMPL(a_sec_micro, i_clk, i_rst_n, o_note.valid && (o_note.duration_seconds != '0), o_note.duration_micro != '0)
    `SENDEC_ASSERT_IMPL(a_semi_range, i_clk, i_rst_n, o_note.valid, o_note.semitone < 4'd12)
    `SENDEC_ASSERT_NEXT(a_tie_closed, i_clk, i_rst_n, advance && r_s1_valid && ch_ok && r_s1_last, !r_tie[$past(r_s1_ch)])

endmodule

@@ sv/sendec_time_split.sv @@
// Splits a note duration in microseconds into seconds and remainder.
// Reciprocal multiply, back-multiply, one correction; holds the output register.
// Depends on sendec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sendec_time_split (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sendec_pkg::t_pipe_ctl i_ctl,
    input  sendec_pkg::t_note_req i_req,
    output logic                  o_res_valid,
    output sendec_pkg::t_note_res o_res
);
    import sendec_pkg::*;

    localparam int XS_W = DUR_W - SEC_PRE_SHIFT;
    localparam int QP_W = XS_W + 15;

    // stage A: request, minus-one value, big flag
    logic             r_a_valid;
    t_note_req        r_a_req;
    logic [DUR_W-1:0] r_a_x;
    logic             r_a_big;

    // stage B: seconds estimate
    logic             r_b_valid;
    t_note_req        r_b_req;
    logic [DUR_W-1:0] r_b_x;
    logic             r_b_big;
    logic [SEC_W-1:0] r_b_q0;

    // stage C: back product
    logic             r_c_valid;
    t_note_req        r_c_req;
    logic [DUR_W-1:0] r_c_x;
    logic             r_c_big;
    logic [SEC_W-1:0] r_c_q0;
    logic [DUR_W-1:0] r_c_prod;

    logic             r_out_valid;
    t_note_res        r_out;

    logic [QP_W-1:0]          q_prod;
    logic [SEC_W+MICRO_W-1:0] back_prod;
    logic [DUR_W-1:0]         rem_raw;
    logic [DUR_W-1:0]         rem_fix;
    logic [SEC_W-1:0]         q_fix;
    t_note_res                n_out;

    assign q_prod    = QP_W'(r_a_x[DUR_W-1:SEC_PRE_SHIFT]) * QP_W'(SEC_RECIP);
    assign back_prod = (SEC_W+MICRO_W)'(r_b_q0) * (SEC_W+MICRO_W)'(MICRO_PER_SEC);
    assign rem_raw   = r_c_x - r_c_prod;

    always_comb begin
        if (rem_raw >= MICRO_PER_SEC) begin
            rem_fix = rem_raw - MICRO_PER_SEC;
            q_fix   = r_c_q0 + SEC_W'(1);
        end else begin
            rem_fix = rem_raw;
            q_fix   = r_c_q0;
        end
        n_out.ch       = r_c_req.ch;
        n_out.semitone = r_c_req.semitone;
        n_out.slot     = r_c_req.slot;
        n_out.volume   = r_c_req.volume;
        n_out.last     = r_c_req.last;
        if (r_c_big) begin
            n_out.seconds = q_fix;
            n_out.micro   = rem_fix[MICRO_W-1:0] + MICRO_W'(1);
        end else begin
            n_out.seconds = '0;
            n_out.micro   = r_c_req.total[MICRO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_a_valid   <= i_ctl.valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_a_req  <= i_req;
            r_a_x    <= i_req.total - DUR_W'(1);
            r_a_big  <= (i_req.total > MICRO_PER_SEC);
            r_b_req  <= r_a_req;
            r_b_x    <= r_a_x;
            r_b_big  <= r_a_big;
            r_b_q0   <= q_prod[SEC_SHIFT +: SEC_W];
            r_c_req  <= r_b_req;
            r_c_x    <= r_b_x;
            r_c_big  <= r_b_big;
            r_c_q0   <= r_b_q0;
            r_c_prod <= back_prod[DUR_W-1:0];
            r_out    <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `SENDEC_ASSERT_IMPL(a_q0_range, i_clk, i_rst_n, r_b_valid && r_b_big, r_b_q0 <= MAX_SECONDS)
    `SENDEC_ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, r_c_valid && r_c_big, rem_raw < (MICRO_PER_SEC << 1))
    `SENDEC_ASSERT_NEXT(a_big_has_sec, i_clk, i_rst_n, r_c_valid && r_c_big && i_ctl.advance, r_out.seconds != '0)

endmodule

@@ bench/score_event_note_decoder_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for score_event_note_decoder_unit: drives score events through
// sendec_event_if, checks decoded notes on sendec_note_if against a local channel-state model.
// Depends on sendec_pkg, sendec_event_if, sendec_note_if and the unit itself.
module score_event_note_decoder_unit_tb;
    import sendec_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE       = 10;
    localparam int          RAND_PHASES  = 6;
    localparam int          PHASE_EVENTS = 325;
    localparam int          LONG_HOLD    = 300;
    localparam logic [7:0]  TIE          = 8'h40;
    localparam logic [7:0]  CTRL         = 8'h80;
    localparam logic [5:0]  LONG_CODE    = 6'd8;
    localparam int          MAP_ENTRIES  = 8;
    localparam logic [31:0] US_PER_S     = 32'd1000000;
    localparam logic [31:0] DUR_MAX      = 32'hFFFF_FFFF;
    localparam logic [13:0] MAX_TEMPO    = 14'd8929;
    localparam logic [13:0] EXACT_TEMPO  = 14'd3125;  // 320 * tempo = one second
    localparam logic [23:0] IDENT_MAP    = 24'o76543210;
    // base table row heads; each row halves across its eight codes
    localparam logic [15:0] DUR_ROW [8] = '{16'd26880, 16'd40320, 16'd17920, 16'd26880,
                                            16'd21504, 16'd32256, 16'd23040, 16'd34560};

    typedef struct {
        logic [CH_W-1:0]   ch;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_score_evt;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sendec_event_if evt_if ();
    sendec_note_if  note_if ();

    score_event_note_decoder_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_evt      (evt_if),
        .o_note     (note_if)
    );

    t_score_evt pending_events [$];
    t_note_res  expected_notes [$];
    t_score_evt cur_evt;
    int         fail_cnt;
    int         cycle_cnt;
    int         burst_left;
    int         gap_left;
    int         hold_left;
    bit         long_hold_done;
    t_rx_mode   rx_mode;
    int         mode_left;

    // decoder state copy
    logic [TEMPO_W-1:0]  tempo;
    logic [ICOUNT_W-1:0] instr_count;
    logic [IMAP_W-1:0]   instr_map;
    logic [INSTR_W-1:0]  instr_of  [CHANNELS];
    logic [VOL_W-1:0]    vol_of    [CHANNELS];
    bit                  tie_open  [CHANNELS];
    logic [DUR_W-1:0]    dur_total [CHANNELS];
    logic [SEMI_W-1:0]   pend_semi [CHANNELS];
    logic [SLOT_W-1:0]   pend_slot [CHANNELS];
    logic [VOL_W-1:0]    pend_vol  [CHANNELS];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** score_event_note_decoder_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [DUR_W-1:0] code_length(input logic [5:0] code);
        return DUR_W'(DUR_ROW[code[5:3]] >> code[2:0]) * DUR_W'(tempo);
    endfunction

    function automatic logic [DUR_W-1:0] sum_clamped(input logic [DUR_W-1:0] a, b);
        logic [DUR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DUR_W] ? DUR_MAX : s[DUR_W-1:0];
    endfunction

    task automatic decode_event(input t_score_evt e);
        t_note_res        r;
        logic [DUR_W-1:0] total, secs, micro;
        int               note;
        bit               fire;
        fire = 1'b0;
        if (tie_open[e.ch]) begin
            dur_total[e.ch] = sum_clamped(dur_total[e.ch], code_length(e.data[5:0]));
            fire = ((e.data & TIE) == 0) || e.last;
            tie_open[e.ch] = !fire;
        end else if (e.id > ID_REST || (e.data & CTRL) != 0) begin
            if (e.id == ID_INSTR && e.data < instr_count && e.data < MAP_ENTRIES)
                instr_of[e.ch] = INSTR_W'(instr_map >> (3 * e.data));
            if (e.id == ID_VOLUME)
                vol_of[e.ch] = e.data;
        end else begin
            note = (e.id == ID_REST) ? int'(REST_NOTE) : int'(e.id);
            pend_vol[e.ch]  = (e.id == ID_REST) ? '0 : vol_of[e.ch];
            pend_semi[e.ch] = SEMI_W'(note % 12);
            pend_slot[e.ch] = SLOT_W'((9 - note / 12) * 2 + int'(instr_of[e.ch]) * 16);
            dur_total[e.ch] = code_length(e.data[5:0]);
            fire = ((e.data & TIE) == 0) || e.last;
            tie_open[e.ch] = !fire;
        end
        if (fire) begin
            total = dur_total[e.ch];
            secs  = '0;
            micro = total;
            if (total > US_PER_S) begin
                secs  = (total - 1) / US_PER_S;
                micro = total - secs * US_PER_S;
            end
            r.ch       = e.ch;
            r.semitone = pend_semi[e.ch];
            r.slot     = pend_slot[e.ch];
            r.volume   = pend_vol[e.ch];
            r.seconds  = SEC_W'(secs);
            r.micro    = MICRO_W'(micro);
            r.last     = e.last;
            expected_notes.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input longint unsigned want, got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_TEMPO:       tempo       = TEMPO_W'(val);
            CFG_INSTR_COUNT: instr_count = ICOUNT_W'(val);
            CFG_INSTR_MAP:   instr_map   = IMAP_W'(val);
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [TEMPO_W-1:0] t, input logic [ICOUNT_W-1:0] n,
                                 input logic [IMAP_W-1:0] m);
        write_reg(CFG_TEMPO, CFG_DATA_W'(t));
        write_reg(CFG_INSTR_COUNT, CFG_DATA_W'(n));
        write_reg(CFG_INSTR_MAP, m);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_event(input int ch, input logic [7:0] id, data, input bit last);
        t_score_evt e;
        e.ch   = CH_W'(ch);
        e.id   = id;
        e.data = data;
        e.last = last;
        pending_events.push_back(e);
    endtask

    task automatic add_random_events(input int count);
        t_score_evt e;
        int         chain_left [CHANNELS];
        int         pick;
        foreach (chain_left[c]) chain_left[c] = 0;
        for (int k = 0; k < count; k++) begin
            e.ch   = CH_W'($urandom_range(0, CHANNELS - 1));
            e.last = ($urandom_range(0, 47) == 0);
            pick   = $urandom_range(0, 99);
            if (chain_left[e.ch] > 0) begin
                // follow-on of an open tie: id is don't-care
                e.id   = ID_W'($urandom);
                e.data = DATA_W'($urandom);
                if (chain_left[e.ch] > 2)
                    e.data[5:0] = LONG_CODE;
                e.data[6] = (chain_left[e.ch] > 1);
                chain_left[e.ch] = e.last ? 0 : chain_left[e.ch] - 1;
            end else if (pick < 55) begin
                e.id = ($urandom_range(0, 15) == 0) ? ID_REST : ID_W'($urandom_range(0, 127));
                pick = $urandom_range(0, 99);
                chain_left[e.ch] = (pick < 60) ? 0 :
                                   (pick < 95) ? $urandom_range(1, 3) : $urandom_range(12, 18);
                e.data    = DATA_W'($urandom_range(0, 63));
                e.data[6] = (chain_left[e.ch] > 0);
                if (e.last)
                    chain_left[e.ch] = 0;
            end else if (pick < 65) begin
                e.id   = ID_VOLUME;
                e.data = DATA_W'($urandom);
            end else if (pick < 77) begin
                e.id   = ID_INSTR;
                e.data = ($urandom_range(0, 4) == 0) ? DATA_W'($urandom)
                                                      : DATA_W'($urandom_range(0, 9));
            end else if (pick < 87) begin
                if ($urandom_range(0, 1)) begin
                    e.id   = ID_W'($urandom_range(129, 255));
                    e.data = DATA_W'($urandom);
                end else begin
                    e.id   = ID_W'($urandom_range(0, 128));
                    e.data = DATA_W'($urandom_range(128, 255));
                end
            end else begin
                e.id   = ID_W'($urandom);
                e.data = DATA_W'($urandom);
            end
            pending_events.push_back(e);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_events.size() != 0 || evt_if.valid || expected_notes.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.valid <= 1'b0;
        end else begin
            if (evt_if.valid && evt_if.ready)
                decode_event(cur_evt);
            if (!evt_if.valid || evt_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    evt_if.valid <= 1'b0;
                end else if (pending_events.size() == 0) begin
                    evt_if.valid <= 1'b0;
                end else begin
                    cur_evt = pending_events.pop_front();
                    evt_if.valid         <= 1'b1;
                    evt_if.channel       <= cur_evt.ch;
                    evt_if.event_id      <= cur_evt.id;
                    evt_if.event_data    <= cur_evt.data;
                    evt_if.last_in_track <= cur_evt.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 7))
                            0, 1:    gap_left = 0;
                            7:       gap_left = $urandom_range(15, 30);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end
                end
            end
        end
    end

    // result-side ready pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            note_if.ready <= 1'b0;
        end else begin
            if (!long_hold_done && pending_events.size() > 200) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                note_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_FREE:   note_if.ready <= 1'b1;
                    RX_COIN:   note_if.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: note_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   note_if.ready <= !note_if.ready;
                endcase
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_note_res want;
        if (i_rst_n && note_if.valid && note_if.ready) begin
            if (expected_notes.size() == 0) begin
                $error("note on channel %0d with nothing expected", note_if.out_channel);
                fail_cnt++;
            end else begin
                want = expected_notes.pop_front();
                check_field("out_channel", want.ch, note_if.out_channel);
                check_field("semitone", want.semitone, note_if.semitone);
                check_field("sample_slot", want.slot, note_if.sample_slot);
                check_field("note_volume", want.volume, note_if.note_volume);
                check_field("duration_seconds", want.seconds, note_if.duration_seconds);
                check_field("duration_micro", want.micro, note_if.duration_micro);
                check_field("track_done", want.last, note_if.track_done);
            end
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        evt_if.valid         = 1'b0;
        evt_if.channel       = '0;
        evt_if.event_id      = '0;
        evt_if.event_data    = '0;
        evt_if.last_in_track = 1'b0;
        note_if.ready        = 1'b0;
        fail_cnt             = 0;
        cycle_cnt            = 0;
        burst_left           = 1;
        gap_left             = 0;
        hold_left            = 0;
        long_hold_done       = 1'b0;
        rx_mode              = RX_FREE;
        mode_left            = 0;
        tempo                = TEMPO_RESET;
        instr_count          = '0;
        instr_map            = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            instr_of[c]  = '0;
            vol_of[c]    = VOLUME_RESET;
            tie_open[c]  = 1'b0;
            dur_total[c] = '0;
            pend_semi[c] = '0;
            pend_slot[c] = '0;
            pend_vol[c]  = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_setting(EXACT_TEMPO, 4'd15, IDENT_MAP);
        add_event(0, 8'd0, 8'd0, 0);                 // exact whole seconds
        add_event(1, 8'd127, 8'd63, 0);              // top note, slot wraps
        add_event(2, ID_REST, 8'd8, 0);
        add_event(3, ID_VOLUME, 8'd255, 0);
        add_event(3, 8'd60, 8'd1, 0);
        add_event(3, ID_VOLUME, 8'd0, 0);
        add_event(3, 8'd64, 8'd2, 0);
        add_event(0, ID_INSTR, 8'd7, 0);
        add_event(0, ID_INSTR, 8'd8, 0);             // past map, below count
        add_event(0, 8'd12, 8'd0, 0);
        add_event(1, 8'd200, 8'd5, 1);               // control on last: silent
        add_event(1, 8'd5, 8'd200, 0);
        add_event(2, 8'd30, TIE | 8'd55, 0);         // 180 + 140 -> exactly 1 s
        add_event(2, ID_VOLUME, 8'd23, 0);
        add_event(1, 8'd70, TIE | 8'd0, 0);
        add_event(1, 8'd255, CTRL | TIE | 8'd24, 0);
        add_event(1, ID_INSTR, 8'd1, 0);             // follow-on, not an instrument change
        add_event(1, 8'd3, 8'd0, 0);
        add_event(0, 8'd40, TIE, 1);                 // tie open on last
        add_event(3, ID_INSTR, 8'd255, 0);
        add_event(3, ID_INSTR, 8'd3, 0);
        add_event(3, 8'd100, 8'd7, 1);
        add_event(2, ID_REST, TIE | 8'd63, 0);
        add_event(2, 8'd0, 8'd63, 0);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: apply_setting(MAX_TEMPO, 4'd8, 24'hFFFFFF);
                1: apply_setting(14'd0, 4'd0, 24'h000000);
                2: apply_setting(14'd1, ICOUNT_W'($urandom_range(0, 8)), IMAP_W'($urandom));
                3: apply_setting(TEMPO_W'($urandom_range(0, MAX_TEMPO)), 4'd15,
                                 IMAP_W'($urandom));
                4: apply_setting(EXACT_TEMPO, ICOUNT_W'($urandom_range(0, 15)), IDENT_MAP);
                default: apply_setting(TEMPO_W'($urandom_range(0, MAX_TEMPO)),
                                       ICOUNT_W'($urandom_range(0, 8)), IMAP_W'($urandom));
            endcase
            add_random_events(PHASE_EVENTS);
            wait_idle();
        end

        if (fail_cnt == 0) begin
            $display("** score_event_note_decoder_unit: PASSED **");
        end else begin
            $display("** score_event_note_decoder_unit: FAILED **");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/sendec_pkg.sv
sv/sendec_event_if.sv
sv/sendec_note_if.sv
sv/sendec_time_split.sv
sv/score_event_note_decoder_unit.sv
bench/score_event_note_decoder_unit_tb.sv
